@@ design/keyed_stack_remove_by_key_top_defines.svh @@
// assertion macros for the keyed stack block
// used by keyed_stack_remove_by_key_top; relies on its clock and reset ports
`ifndef KEYED_STACK_REMOVE_BY_KEY_TOP_DEFINES_SVH
`define KEYED_STACK_REMOVE_BY_KEY_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define KSRK_ASSERT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define KSRK_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

@@ design/ksrk_pkg.sv @@
// shared constants for the keyed stack block
// no dependencies; imported by the RAM, the top level, the checker and the testbench
`timescale 1ns / 1ps

package ksrk_pkg;

   // default stack depth
   localparam int DEPTH_DEFAULT = 8;

   // field widths
   localparam int KEY_W    = 10;
   localparam int STATUS_W = 3;
   localparam int COUNT_W  = 4;
   localparam int CSR_A_W  = 1;

   // register reset values
   localparam logic [KEY_W-1:0] KEY_MIN_RST = 10'd100;
   localparam logic [KEY_W-1:0] KEY_MAX_RST = 10'd999;

   // register indexes
   localparam logic [CSR_A_W-1:0] REG_KEY_MIN = 1'b0;
   localparam logic [CSR_A_W-1:0] REG_KEY_MAX = 1'b1;

   // request kinds
   localparam logic KIND_INSERT = 1'b0;
   localparam logic KIND_REMOVE = 1'b1;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
   localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
   localparam logic [STATUS_W-1:0] ST_DUP      = 3'd2;
   localparam logic [STATUS_W-1:0] ST_RANGE    = 3'd3;
   localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd4;
   localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd5;

endpackage

@@ design/keyed_stack_remove_by_key_top.sv @@
// keyed stack: bounded stack of unique keys with insert and remove-by-key
// full and empty rejects, range rejects of removes and inserts on an empty stack go straight
// to the result; an insert first scans the n held keys for a duplicate; a remove reads down
// from the top to the hit, then shifts the keys above it down one by one
// one item at a time: the next is taken at the edge its result can first leave, later on stall
// reset (synchronous, active high) empties the stack and restores key_min 100, key_max 999
`timescale 1ns / 1ps

`include "keyed_stack_remove_by_key_top_defines.svh"

module keyed_stack_remove_by_key_top
   import ksrk_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   // request channel
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [15:0]  req_tdata,   // [9:0] key, rest zero
   input  logic         req_tuser,   // [0] kind
   // result channel
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [23:0]  rsp_tdata,   // [2:0] status, [6:3] count_after, [16:7] key_echo
   // configuration
   input  logic                 csr_we,
   input  logic [CSR_A_W-1:0]   csr_addr,
   input  logic [KEY_W-1:0]     csr_wdata
);

   localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);
   localparam logic [COUNT_W-1:0] CNT_FULL_LO = COUNT_W'(DEPTH);

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_DUPCHK = 5'b00010,
      S_FIND   = 5'b00100,
      S_SHIFT  = 5'b01000,
      S_DONE   = 5'b10000
   } state_type;

   state_type            state_ff, state_in;
   logic [KEY_W-1:0]     key_ff, key_in;
   logic [IW-1:0]        ptr_ff, ptr_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [STATUS_W-1:0]  status_ff, status_in;
   logic [KEY_W-1:0]     key_min_ff, key_max_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [COUNT_W-1:0]   rsp_count_ff, rsp_count_in;
   logic [KEY_W-1:0]     rsp_key_ff, rsp_key_in;

   logic                 ram_we, ram_re;
   logic [IW-1:0]        ram_waddr, ram_raddr;
   logic [KEY_W-1:0]     ram_wdata, ram_rdata;

   logic                 req_accept;
   logic [KEY_W-1:0]     req_key;
   logic                 req_in_range, key_in_range;
   logic [CW-1:0]        cnt_m1;
   logic                 at_top;
   logic [IW-1:0]        ptr_next, ptr_prev;
   logic [CW+COUNT_W-1:0] cnt_ext;
   logic                 full_rsp;

   // key storage
   ksrk_ram #(
      .WIDTH (KEY_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // handshake and helpers
   assign req_tready   = (state_ff == S_IDLE);
   assign req_accept   = req_tvalid & req_tready;
   assign req_key      = req_tdata[KEY_W-1:0];
   assign req_in_range = (req_key >= key_min_ff) && (req_key <= key_max_ff);
   assign key_in_range = (key_ff >= key_min_ff) && (key_ff <= key_max_ff);
   assign cnt_m1       = count_ff - 1'b1;
   assign at_top       = (CW'(ptr_ff) == cnt_m1);
   assign ptr_next     = ptr_ff + 1'b1;
   assign ptr_prev     = ptr_ff - 1'b1;
   assign cnt_ext      = (CW + COUNT_W)'(count_ff);

   // sequencer: scan, search and compaction through the RAM
   always_comb begin
      state_in      = state_ff;
      key_in        = key_ff;
      ptr_in        = ptr_ff;
      count_in      = count_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_key_in    = rsp_key_ff;
      ram_we        = 1'b0;
      ram_waddr     = '0;
      ram_wdata     = key_ff;
      ram_re        = 1'b0;
      ram_raddr     = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               key_in = req_key;
               if (req_tuser == KIND_INSERT) begin
                  if (count_ff == CNT_FULL) begin
                     status_in = ST_FULL;
                     state_in  = S_DONE;
                  end else if (count_ff == '0) begin
                     // nothing held, so only the range matters
                     if (req_in_range) begin
                        ram_we    = 1'b1;
                        ram_waddr = '0;
                        ram_wdata = req_key;
                        count_in  = count_ff + 1'b1;
                        status_in = ST_OK;
                     end else begin
                        status_in = ST_RANGE;
                     end
                     state_in = S_DONE;
                  end else begin
                     ram_re    = 1'b1;
                     ram_raddr = '0;
                     ptr_in    = '0;
                     state_in  = S_DUPCHK;
                  end
               end else begin
                  if (count_ff == '0) begin
                     status_in = ST_EMPTY;
                     state_in  = S_DONE;
                  end else if (!req_in_range) begin
                     status_in = ST_RANGE;
                     state_in  = S_DONE;
                  end else begin
                     ram_re    = 1'b1;
                     ram_raddr = cnt_m1[IW-1:0];
                     ptr_in    = cnt_m1[IW-1:0];
                     state_in  = S_FIND;
                  end
               end
            end
         end
         S_DUPCHK: begin
            // duplicate scan from the bottom over occupied entries
            if (ram_rdata == key_ff) begin
               status_in = ST_DUP;
               state_in  = S_DONE;
            end else if (at_top) begin
               if (key_in_range) begin
                  ram_we    = 1'b1;
                  ram_waddr = count_ff[IW-1:0];
                  ram_wdata = key_ff;
                  count_in  = count_ff + 1'b1;
                  status_in = ST_OK;
               end else begin
                  status_in = ST_RANGE;
               end
               state_in = S_DONE;
            end else begin
               ram_re    = 1'b1;
               ram_raddr = ptr_next;
               ptr_in    = ptr_next;
            end
         end
         S_FIND: begin
            // search downwards from the top
            if (ram_rdata == key_ff) begin
               if (at_top) begin
                  count_in  = cnt_m1;
                  status_in = ST_OK;
                  state_in  = S_DONE;
               end else begin
                  ram_re    = 1'b1;
                  ram_raddr = ptr_next;
                  ptr_in    = ptr_next;
                  state_in  = S_SHIFT;
               end
            end else if (ptr_ff == '0) begin
               status_in = ST_NOTFOUND;
               state_in  = S_DONE;
            end else begin
               ram_re    = 1'b1;
               ram_raddr = ptr_prev;
               ptr_in    = ptr_prev;
            end
         end
         S_SHIFT: begin
            // move each entry above the hit down by one
            ram_we    = 1'b1;
            ram_waddr = ptr_prev;
            ram_wdata = ram_rdata;
            if (at_top) begin
               count_in  = cnt_m1;
               status_in = ST_OK;
               state_in  = S_DONE;
            end else begin
               ram_re    = 1'b1;
               ram_raddr = ptr_next;
               ptr_in    = ptr_next;
            end
         end
         S_DONE: begin
            // hand the item to the output register once it is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_count_in  = cnt_ext[COUNT_W-1:0];
               rsp_key_in    = key_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      key_ff        <= key_in;
      ptr_ff        <= ptr_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_key_ff    <= rsp_key_in;
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         key_min_ff <= KEY_MIN_RST;
         key_max_ff <= KEY_MAX_RST;
      end else if (csr_we) begin
         unique case (csr_addr)
            REG_KEY_MIN: key_min_ff <= csr_wdata;
            REG_KEY_MAX: key_max_ff <= csr_wdata;
            default:     key_min_ff <= key_min_ff;
         endcase
      end
   end

   // result channel
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_key_ff, rsp_count_ff, rsp_status_ff};

   // checks
   assign full_rsp = rsp_valid_ff && (rsp_status_ff == ST_FULL);

   `KSRK_ASSERT(a_count_bound, 1'b1, count_ff <= CNT_FULL, "entry count above depth")
   `KSRK_ASSERT(a_wr_state, ram_we, (state_ff != S_DONE) && (state_ff != S_FIND), "bad RAM write")
   `KSRK_ASSERT_NEXT(a_idle_count, req_tready && !req_tvalid, $stable(count_ff), "idle count moved")
   `KSRK_ASSERT(a_full_count, full_rsp, rsp_count_ff == CNT_FULL_LO, "short count on full")

endmodule

@@ design/ksrk_ram.sv @@
// generic simple dual-port RAM, one write and one registered read port
// depends on ksrk_pkg for default sizes
`timescale 1ns / 1ps

module ksrk_ram
   import ksrk_pkg::*;
#(
   parameter int WIDTH = KEY_W,
   parameter int DEPTH = DEPTH_DEFAULT,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sim/keyed_stack_checker.sv @@
// result checker for the keyed stack: watches the request, result and register ports
// keeps its own copy of the stack and range registers; depends on ksrk_pkg
`timescale 1ns / 1ps

module keyed_stack_checker
   import ksrk_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   input  logic                req_tready,
   input  logic [15:0]         req_tdata,   // [9:0] key, rest zero
   input  logic                req_tuser,   // [0] kind
   input  logic                rsp_tvalid,
   input  logic                rsp_tready,
   input  logic [23:0]         rsp_tdata,   // [2:0] status, [6:3] count_after, [16:7] key_echo
   input  logic                csr_we,
   input  logic [CSR_A_W-1:0]  csr_addr,
   input  logic [KEY_W-1:0]    csr_wdata,
   output int                  fail_count,
   output int                  pending
);

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [COUNT_W-1:0]  count_after;
      logic [KEY_W-1:0]    key_echo;
   } stack_result_type;

   // shadow of the block state
   logic [KEY_W-1:0] held_keys [DEPTH];
   int               held_n;
   logic [KEY_W-1:0] range_lo;
   logic [KEY_W-1:0] range_hi;
   stack_result_type outcome_q [$];

   // work out the result of one request and update the shadow stack
   function automatic stack_result_type apply_request(input logic kind,
                                                      input logic [KEY_W-1:0] key);
      stack_result_type r;
      logic             dup;
      logic             in_rng;
      int               pos;
      r.status = ST_OK;
      r.key_echo = key;
      in_rng = (key >= range_lo) && (key <= range_hi);
      if (kind == KIND_INSERT) begin
         dup = 1'b0;
         for (int i = 0; i < held_n; i++)
            if (held_keys[i] == key) dup = 1'b1;
         // full first, then duplicate, then range
         if (held_n >= DEPTH) r.status = ST_FULL;
         else if (dup) r.status = ST_DUP;
         else if (!in_rng) r.status = ST_RANGE;
         else begin
            held_keys[held_n] = key;
            held_n++;
         end
      end else begin
         if (held_n == 0) r.status = ST_EMPTY;
         else if (!in_rng) r.status = ST_RANGE;
         else begin
            // search from the top, then close the gap
            pos = -1;
            for (int i = held_n - 1; i >= 0 && pos < 0; i--)
               if (held_keys[i] == key) pos = i;
            if (pos < 0) r.status = ST_NOTFOUND;
            else begin
               for (int j = pos; j < held_n - 1; j++)
                  held_keys[j] = held_keys[j + 1];
               held_n--;
            end
         end
      end
      r.count_after = COUNT_W'(held_n);
      return r;
   endfunction

   // sample all ports at the rising edge
   always @(posedge clock) begin
      stack_result_type want;
      stack_result_type got;
      if (reset) begin
         held_n = 0;
         range_lo = KEY_MIN_RST;
         range_hi = KEY_MAX_RST;
         outcome_q.delete();
         fail_count = 0;
      end else begin
         // register writes
         if (csr_we) begin
            if (csr_addr == REG_KEY_MIN) range_lo = csr_wdata;
            else if (csr_addr == REG_KEY_MAX) range_hi = csr_wdata;
         end
         // result items
         if (rsp_tvalid && rsp_tready) begin
            got.status = rsp_tdata[STATUS_W-1:0];
            got.count_after = rsp_tdata[STATUS_W +: COUNT_W];
            got.key_echo = rsp_tdata[STATUS_W + COUNT_W +: KEY_W];
            if (outcome_q.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected result item: expected none, actual %h",
                        $time, got);
            end else begin
               want = outcome_q.pop_front();
               if (got.status !== want.status) begin
                  fail_count++;
                  $display("%0t: status mismatch: expected %0d, actual %0d",
                           $time, want.status, got.status);
               end
               if (got.count_after !== want.count_after) begin
                  fail_count++;
                  $display("%0t: count_after mismatch: expected %0d, actual %0d",
                           $time, want.count_after, got.count_after);
               end
               if (got.key_echo !== want.key_echo) begin
                  fail_count++;
                  $display("%0t: key_echo mismatch: expected %0d, actual %0d",
                           $time, want.key_echo, got.key_echo);
               end
            end
         end
         // request items
         if (req_tvalid && req_tready)
            outcome_q.push_back(apply_request(req_tuser, req_tdata[KEY_W-1:0]));
      end
      pending = outcome_q.size();
   end

endmodule

@@ sim/testbench.sv @@
// top of the keyed stack testbench: clock, reset, request and register stimulus, verdict
// depends on ksrk_pkg, keyed_stack_checker and keyed_stack_remove_by_key_top
`timescale 1ns / 1ps

module testbench;
   import ksrk_pkg::*;

   localparam int STACK_DEPTH = DEPTH_DEFAULT;
   localparam int CYCLE_LIMIT = 400000;
   localparam int PHASE_ITEMS = 115;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [15:0]         req_tdata = '0;   // [9:0] key, rest zero
   logic                req_tuser = 1'b0; // [0] kind
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [23:0]         rsp_tdata;        // [2:0] status, [6:3] count_after, [16:7] key_echo
   logic                csr_we = 1'b0;
   logic [CSR_A_W-1:0]  csr_addr = '0;
   logic [KEY_W-1:0]    csr_wdata = '0;

   int fail_count;
   int pending;
   int cycles = 0;
   int stall_left = 0;
   int stall_pct = 0;
   int idle_pct = 0;
   bit quiet = 1'b0;

   keyed_stack_remove_by_key_top #(.DEPTH(STACK_DEPTH)) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   keyed_stack_checker #(.DEPTH(STACK_DEPTH)) u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("testbench failed");
         $finish;
      end
   end

   // result back-pressure in random bursts
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left--;
      end else if (!quiet && $urandom_range(0, 99) < stall_pct) begin
         rsp_tready <= 1'b0;
         stall_left = $urandom_range(1, 11) - 1;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // present one request item and hold it until accepted
   task automatic send_item(input logic kind, input logic [KEY_W-1:0] key);
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= 16'(key);
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   // stop sending and let every outstanding result arrive, plus a search's worth
   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (STACK_DEPTH + 8) @(negedge clock);
   endtask

   // write both range registers on consecutive cycles
   task automatic set_range(input logic [KEY_W-1:0] lo, input logic [KEY_W-1:0] hi);
      csr_we <= 1'b1;
      csr_addr <= REG_KEY_MIN;
      csr_wdata <= lo;
      @(negedge clock);
      csr_addr <= REG_KEY_MAX;
      csr_wdata <= hi;
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   initial begin
      logic [KEY_W-1:0] lo;
      logic [KEY_W-1:0] hi;
      logic [KEY_W-1:0] pool_base;
      logic [KEY_W-1:0] key;
      logic             kind;
      int               pick;

      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: reset range of 100 to 999
      send_item(KIND_REMOVE, 10'd500);    // remove on empty stack
      send_item(KIND_INSERT, 10'd99);     // just below range
      send_item(KIND_INSERT, 10'd1000);   // just above range
      send_item(KIND_INSERT, 10'd0);
      send_item(KIND_INSERT, 10'd1023);
      send_item(KIND_INSERT, 10'd100);
      send_item(KIND_INSERT, 10'd999);
      send_item(KIND_INSERT, 10'd100);    // duplicate
      send_item(KIND_REMOVE, 10'd99);     // out of range on a non-empty stack
      send_item(KIND_REMOVE, 10'd500);    // key not held
      send_item(KIND_INSERT, 10'd200);
      send_item(KIND_INSERT, 10'd300);
      send_item(KIND_INSERT, 10'd400);
      send_item(KIND_INSERT, 10'd500);
      send_item(KIND_INSERT, 10'd600);
      send_item(KIND_INSERT, 10'd700);
      send_item(KIND_INSERT, 10'd800);    // full
      send_item(KIND_INSERT, 10'd100);    // full wins over duplicate
      send_item(KIND_INSERT, 10'd5);      // full wins over range
      send_item(KIND_REMOVE, 10'd400);    // middle, entries above shift down
      send_item(KIND_REMOVE, 10'd700);    // top
      send_item(KIND_REMOVE, 10'd100);    // bottom
      send_item(KIND_REMOVE, 10'd400);    // already gone
      send_item(KIND_INSERT, 10'd400);
      drain();

      // directed: min above max, nothing in range
      set_range(10'd1023, 10'd0);
      send_item(KIND_INSERT, 10'd200);    // duplicate wins over range
      send_item(KIND_INSERT, 10'd512);
      send_item(KIND_REMOVE, 10'd200);
      drain();

      // random phases, each with its own range
      for (int p = 0; p < 8; p++) begin
         case (p)
            0: begin lo = 10'd0;    hi = 10'd1023; end
            1: begin lo = 10'd100;  hi = 10'd999;  end
            2: begin lo = 10'd300;  hi = 10'd310;  end
            3: begin lo = 10'd1023; hi = 10'd0;    end
            4: begin lo = 10'd0;    hi = 10'd0;    end
            5: begin lo = 10'd1023; hi = 10'd1023; end
            6: begin lo = 10'd512;  hi = 10'd700;  end
            default: begin
               lo = 10'($urandom_range(0, 900));
               hi = lo + 10'($urandom_range(0, 123));
            end
         endcase
         set_range(lo, hi);
         quiet = (p == 7);
         // phases 1, 4 and 7 run without any idling
         idle_pct = (p == 1 || p == 4 || p == 7) ? 0 : 25;
         stall_pct = (p == 1 || p == 4 || p == 7) ? 0 : 20;
         pool_base = (lo <= hi) ? 10'(lo + $urandom_range(0, hi - lo) - 6)
                                : 10'($urandom);

         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // mostly a small pool of keys near the range, so hits are common
            pick = $urandom_range(0, 99);
            if (pick < 75) key = pool_base + 10'($urandom_range(0, 11));
            else if (pick < 80) begin
               case ($urandom_range(0, 3))
                  0: key = lo;
                  1: key = hi;
                  2: key = lo - 10'd1;
                  default: key = hi + 10'd1;
               endcase
            end else key = 10'($urandom);
            kind = ($urandom_range(0, 99) < 55) ? KIND_INSERT : KIND_REMOVE;

            // hold off once mid-phase until every result is back
            if (p == 2 && n == 57) drain();
            else if (!quiet && $urandom_range(0, 99) < idle_pct) begin
               req_tvalid <= 1'b0;
               repeat ($urandom_range(1, 11)) @(negedge clock);
            end
            send_item(kind, key);
         end
         drain();
      end

      if (fail_count == 0)
         $display("testbench passed");
      else
         $display("testbench failed");
      $finish;
   end

endmodule

@@ keyed_stack_remove_by_key_top.f @@
+incdir+design
design/ksrk_pkg.sv
design/ksrk_ram.sv
design/keyed_stack_remove_by_key_top.sv
sim/keyed_stack_checker.sv
sim/testbench.sv
